// ===== design/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

    localparam int MAP_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = MAP_PAGES / WORD_BITS;
    localparam int WIX_W      = $clog2(MAP_WORDS);
    localparam int BIX_W      = $clog2(WORD_BITS);
    localparam int PIX_W      = $clog2(MAP_PAGES);
    localparam int SCAN_BITS  = 8;
    localparam int PAGE_W     = 40;
    localparam int CNT_W      = 13;

    typedef enum logic [2:0] {
        CMD_ALLOC = 3'd0,
        CMD_FREE  = 3'd1,
        CMD_MARK  = 3'd2,
        CMD_QUERY = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_NO_FIT          = 3'd1,
        ST_OUTSIDE_IGNORED = 3'd2,
        ST_NOT_USED        = 3'd3,
        ST_OUTSIDE         = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        REG_BASE  = 1'b0,
        REG_PAGES = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_DECIDE, S_A_RD, S_A_SCAN,
        S_C_RD, S_C_CHK, S_W_RD, S_W_WR, S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        command;
        logic [PAGE_W-1:0] range_page;
        logic [CNT_W-1:0]  range_count;
        logic              mark_used;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [PAGE_W-1:0] result_page;
        logic [CNT_W-1:0]  result_count;
        logic              range_used;
    } t_out_item;

    typedef struct packed {
        logic    item_load;
        logic    setup;
        logic    st_set;
        t_status st_val;
        logic    used_set;
        logic    used_val;
        logic    a_start;
        logic    a_rd;
        logic    a_step;
        logic    c_start;
        logic    w_rd;
        logic    wix_inc;
        logic    wr;
        logic    wval;
        logic    clr_map;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       mark;
        logic       cnt_zero;
        logic       in_free;
        logic       in_rng;
        logic       fit_over;
        logic       a_end;
        logic       a_found;
        logic       a_step_end;
        logic       a_word_end;
        logic       chk_ok;
        logic       w_last;
        logic       out_free;
    } t_dp_sts;

endpackage

// ===== design/bpa_dpath.sv =====
// Datapath: used map memory, range registers, scan logic and result register.
module bpa_dpath import bpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [PAGE_W-1:0] i_cfg_data,
    input  logic      i_out_ready,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    logic [PAGE_W-1:0] r_base;
    logic [CNT_W-1:0]  r_rpages;
    logic [2:0]        r_cmd;
    logic [PAGE_W-1:0] r_page;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_mark;
    logic [PAGE_W-1:0] r_diff;
    logic              r_below;
    logic [CNT_W-1:0]  r_cur;
    logic [CNT_W-1:0]  r_run;
    logic [PIX_W-1:0]  r_first;
    logic [CNT_W-1:0]  r_s;
    logic [CNT_W:0]    r_e;
    logic [WIX_W-1:0]  r_wix;
    t_status           r_status;
    logic              r_used;
    logic              r_aok;
    logic              r_ovld;
    t_out_item         r_out;

    logic [CNT_W-1:0]     lim;
    logic [WORD_BITS-1:0] rword;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wdata;
    logic [PAGE_W:0]      diff_ext;
    logic [PAGE_W:0]      span;
    logic [CNT_W:0]       off_end;
    logic [CNT_W:0]       e_m1;
    logic [CNT_W:0]       cur_nx;
    logic [CNT_W-1:0]     n_run;
    logic                 n_found;
    logic [CNT_W:0]       n_first;
    logic [WIX_W-1:0]     rd_addr;
    logic                 out_load;

    assign lim   = (r_rpages > CNT_W'(MAP_PAGES)) ? CNT_W'(MAP_PAGES) : r_rpages;
    assign rword = r_rvld ? r_rdata : '0;
    assign diff_ext = {1'b0, r_page} - {1'b0, r_base};
    assign span     = {1'b0, r_diff} + {{(PAGE_W+1-CNT_W){1'b0}}, r_cnt};
    assign off_end  = {1'b0, r_diff[CNT_W-1:0]} + {1'b0, r_cnt};
    assign e_m1     = r_e - 1'b1;
    assign cur_nx   = {1'b0, r_cur} + (CNT_W+1)'(SCAN_BITS);

    always_comb begin
        logic [PIX_W:0] idx;
        for (int k = 0; k < WORD_BITS; k++) begin
            idx = {1'b0, r_wix, BIX_W'(k)};
            mask[k] = ({1'b0, idx} >= {1'b0, r_s}) && ({1'b0, idx} < r_e);
        end
    end

    assign wdata = (rword & ~mask) | (i_cmd.wval ? mask : '0);

    // Walk eight pages of the current word, counting the free run.
    always_comb begin
        logic [CNT_W-1:0] pg;
        logic [BIX_W-1:0] bi;
        n_run   = r_run;
        n_found = 1'b0;
        n_first = '0;
        for (int j = 0; j < SCAN_BITS; j++) begin
            pg = r_cur + CNT_W'(j);
            bi = {r_cur[BIX_W-1:3], 3'(j)};
            if (!n_found && pg < lim) begin
                n_run = rword[bi] ? '0 : n_run + 1'b1;
                if (n_run == r_cnt) begin
                    n_found = 1'b1;
                    n_first = {1'b0, pg} + 1'b1 - {1'b0, r_cnt};
                end
            end
        end
    end

    assign rd_addr = i_cmd.a_rd ? r_cur[PIX_W-1:BIX_W] : r_wix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.a_rd || i_cmd.w_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_cmd.wr) begin
            r_mem[r_wix] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_cmd.a_rd || i_cmd.w_rd) begin
                r_rvld <= r_vld[rd_addr];
            end
            if (i_cmd.clr_map) begin
                r_vld <= '0;
            end else if (i_cmd.wr) begin
                r_vld[r_wix] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_rpages <= CNT_W'(MAP_PAGES);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE:  r_base   <= i_cfg_data;
                REG_PAGES: r_rpages <= i_cfg_data[CNT_W-1:0];
                default:   r_base   <= r_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_cmd    <= i_item.command;
            r_page   <= i_item.range_page;
            r_cnt    <= i_item.range_count;
            r_mark   <= i_item.mark_used;
            r_status <= ST_OK;
            r_used   <= 1'b0;
            r_aok    <= 1'b0;
        end
        if (i_cmd.setup) begin
            r_diff  <= diff_ext[PAGE_W-1:0];
            r_below <= diff_ext[PAGE_W];
        end
        if (i_cmd.st_set) begin
            r_status <= i_cmd.st_val;
        end
        if (i_cmd.used_set) begin
            r_used <= i_cmd.used_val;
        end
        if (i_cmd.a_start) begin
            r_cur <= '0;
            r_run <= '0;
        end
        if (i_cmd.a_step) begin
            r_cur <= cur_nx[CNT_W-1:0];
            r_run <= n_run;
            if (n_found) begin
                r_first <= n_first[PIX_W-1:0];
                r_s     <= {1'b0, n_first[PIX_W-1:0]};
                r_e     <= n_first + {1'b0, r_cnt};
                r_wix   <= n_first[PIX_W-1:BIX_W];
                r_aok   <= 1'b1;
            end
        end
        if (i_cmd.c_start) begin
            r_s   <= {1'b0, r_diff[PIX_W-1:0]};
            r_e   <= off_end;
            r_wix <= r_diff[PIX_W-1:BIX_W];
        end
        if (i_cmd.wix_inc) begin
            r_wix <= r_wix + 1'b1;
        end
    end

    assign out_load = i_cmd.out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.status       <= r_status;
            r_out.result_page  <= r_aok ? r_base + PAGE_W'(r_first) : '0;
            r_out.result_count <= r_aok ? r_cnt : '0;
            r_out.range_used   <= r_used;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.mark       = r_mark;
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.in_free    = !r_below && (r_diff < PAGE_W'(lim));
        o_sts.in_rng     = !r_below && (span <= (PAGE_W+1)'(lim));
        o_sts.fit_over   = off_end > {1'b0, lim};
        o_sts.a_end      = r_cur >= lim;
        o_sts.a_found    = n_found;
        o_sts.a_step_end = cur_nx >= {1'b0, lim};
        o_sts.a_word_end = (cur_nx[BIX_W-1:0] == '0);
        o_sts.chk_ok     = &(rword | ~mask);
        o_sts.w_last     = (r_wix == e_m1[PIX_W-1:BIX_W]);
        o_sts.out_free   = !r_ovld || i_out_ready;
    end

endmodule

// ===== design/bpa_ctrl.sv =====
// Controller: sequences each command over the map words.
module bpa_ctrl import bpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_wval, n_wval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wval  <= n_wval;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_wval     = r_wval;
        o_cmd      = '0;
        o_cmd.wval = r_wval;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (i_sts.cmd)
                    CMD_ALLOC: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_NO_FIT;
                        end else begin
                            o_cmd.a_start = 1'b1;
                            n_wval  = 1'b1;
                            n_state = S_A_RD;
                        end
                    end
                    CMD_FREE: begin
                        if (!i_sts.in_free) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_OUTSIDE_IGNORED;
                        end else if (i_sts.cnt_zero) begin
                            n_state = S_DONE;
                        end else if (i_sts.fit_over) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_NOT_USED;
                        end else begin
                            o_cmd.c_start = 1'b1;
                            n_wval  = 1'b0;
                            n_state = S_C_RD;
                        end
                    end
                    CMD_MARK: begin
                        if (!i_sts.in_rng) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_OUTSIDE;
                        end else if (!i_sts.cnt_zero) begin
                            o_cmd.c_start = 1'b1;
                            n_wval  = i_sts.mark;
                            n_state = S_W_RD;
                        end
                    end
                    CMD_QUERY: begin
                        if (!i_sts.in_rng) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = ST_OUTSIDE;
                        end else if (i_sts.cnt_zero) begin
                            o_cmd.used_set = 1'b1;
                            o_cmd.used_val = 1'b1;
                        end else begin
                            o_cmd.c_start = 1'b1;
                            n_state = S_C_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        o_cmd.clr_map = 1'b1;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_A_RD: begin
                if (i_sts.a_end) begin
                    o_cmd.st_set = 1'b1;
                    o_cmd.st_val = ST_NO_FIT;
                    n_state = S_DONE;
                end else begin
                    o_cmd.a_rd = 1'b1;
                    n_state = S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                o_cmd.a_step = 1'b1;
                if (i_sts.a_found) begin
                    n_state = S_W_RD;
                end else if (i_sts.a_step_end) begin
                    o_cmd.st_set = 1'b1;
                    o_cmd.st_val = ST_NO_FIT;
                    n_state = S_DONE;
                end else if (i_sts.a_word_end) begin
                    n_state = S_A_RD;
                end
            end
            S_C_RD: begin
                o_cmd.w_rd = 1'b1;
                n_state = S_C_CHK;
            end
            S_C_CHK: begin
                if (!i_sts.chk_ok) begin
                    // query reports not used; free refuses the range
                    if (i_sts.cmd == CMD_FREE) begin
                        o_cmd.st_set = 1'b1;
                        o_cmd.st_val = ST_NOT_USED;
                    end
                    n_state = S_DONE;
                end else if (!i_sts.w_last) begin
                    o_cmd.wix_inc = 1'b1;
                    n_state = S_C_RD;
                end else if (i_sts.cmd == CMD_FREE) begin
                    o_cmd.c_start = 1'b1;
                    n_state = S_W_RD;
                end else begin
                    o_cmd.used_set = 1'b1;
                    o_cmd.used_val = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_W_RD: begin
                o_cmd.w_rd = 1'b1;
                n_state = S_W_WR;
            end
            S_W_WR: begin
                o_cmd.wr = 1'b1;
                if (i_sts.w_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.wix_inc = 1'b1;
                    n_state = S_W_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/bitmap_page_allocator_core.sv =====
// Top level of the bitmap first-fit page frame allocator.
//
//  channel | handshake                  | beat
//  in      | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One command at a time. Setup passes the setup and decide states;
// allocate scans 8 pages a cycle, pausing for one memory read per
// 64-page word; range checks and writes read each word, then check or write it.
// Reset clears the row valid bits, so the map reads all free at once.
// A finished result waits in the output register; the next command is
// taken meanwhile and stalls only at its own result load.
module bitmap_page_allocator_core import bpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [PAGE_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bpa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
